FILE: rtl/first_match_packet_rule_classifier_assert.svh
// Assertion macros used by the checker file fmpc_checker.sv.
`ifndef FIRST_MATCH_PACKET_RULE_CLASSIFIER_ASSERT_SVH
`define FIRST_MATCH_PACKET_RULE_CLASSIFIER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FMPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FMPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fmpc_pkg.sv
// ----------------------------------------------------------------------------
// fmpc_pkg
// Types, codes and constants of the first-match packet rule classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fmpc_pkg;

  localparam int MAX_RULES_DEF = 64;
  localparam int PORT_SHIFT    = 16;

  localparam logic [1:0] ACT_CLASSIFY = 2'd0;
  localparam logic [1:0] ACT_INSERT   = 2'd1;
  localparam logic [1:0] ACT_DELETE   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NO_PRED   = 2'd2;

  localparam logic [1:0] VD_NONE      = 2'd0;
  localparam logic [1:0] VD_DROP      = 2'd1;
  localparam logic [1:0] VD_ACCEPT    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rule_name;
    logic [7:0]  after_name;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [31:0] src_ports;
    logic [31:0] dst_ports;
    logic [7:0]  protocol;
    logic        permit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] verdict;
    logic [5:0] matched_index;
    logic [6:0] deleted_count;
    logic       add_session;
  } res_t;

  typedef struct packed {
    logic [7:0]  name;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [31:0] src_ports;
    logic [31:0] dst_ports;
    logic [7:0]  protocol;
    logic        permit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic hit;
    logic name_eq;
  } match_t;

endpackage

`default_nettype wire

FILE: rtl/fmpc_ram.sv
// ----------------------------------------------------------------------------
// fmpc_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/fmpc_match.sv
// ----------------------------------------------------------------------------
// fmpc_match
// Shared compare unit: tests one stored rule against the packet and a name key.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpc_match (
  input  wire fmpc_pkg::entry_t entry,
  input  wire fmpc_pkg::cmd_t   cmd,
  input  wire logic [7:0]       key,
  output fmpc_pkg::match_t      result
);
  import fmpc_pkg::*;

  logic        src_ok;
  logic        dst_ok;
  logic        port_ok;
  logic        proto_ok;
  logic [15:0] sp;
  logic [15:0] dp;

  assign sp = cmd.src_ports[15:0];
  assign dp = cmd.dst_ports[15:0];

  always_comb begin
    src_ok = ((cmd.src_addr & entry.src_mask) == (entry.src_addr & entry.src_mask))
          || (entry.src_addr == 32'd0) || (cmd.src_addr == entry.src_addr);
    dst_ok = (cmd.dst_addr == entry.dst_addr)
          || ((cmd.dst_addr & entry.dst_mask) == (entry.dst_addr & entry.dst_mask));
    // range is packed first in the high half, last in the low half
    port_ok = (sp >= entry.src_ports[31:PORT_SHIFT]) && (sp <= entry.src_ports[15:0])
           && (dp >= entry.dst_ports[31:PORT_SHIFT]) && (dp <= entry.dst_ports[15:0]);
    proto_ok = (entry.protocol == 8'd0) || (entry.protocol == cmd.protocol);
    result.hit     = src_ok && dst_ok && port_ok && proto_ok;
    result.name_eq = (entry.name == key);
  end

endmodule

`default_nettype wire

FILE: rtl/first_match_packet_rule_classifier.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier
// Ordered first-match rule table with insert, delete-by-name and classify.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the single result has been shown. The result is valid for exactly one cycle
// with done high and cannot be held off, so capture it then. The rules sit in
// one RAM with a registered read, visited one entry at a time by a shared
// compare unit. Classify reads entries in order until the first hit, delete
// reads every stored rule, insert searches for the predecessor if one is named
// and then moves the entries below it down by one. The next command can be
// taken in the cycle after the result shows. A full-table insert or an
// empty-table classify or delete goes straight to the result. No clearing
// pass: entries are only read below the rule count. default_accept is written
// through the cfg channel, always ready.
`default_nettype none

module first_match_packet_rule_classifier #(
  parameter int MAX_RULES = fmpc_pkg::MAX_RULES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire fmpc_pkg::cmd_t item,
  output logic               done,
  output fmpc_pkg::res_t     result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);
  import fmpc_pkg::*;

  localparam int IW = $clog2(MAX_RULES);
  localparam int CW = $clog2(MAX_RULES + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_EV  = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_PUT      = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]    state;
  logic          default_accept;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] wptr;
  logic [CW-1:0] dcnt;
  logic [CW-1:0] pos;
  cmd_t          cmd;
  res_t          res;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  entry_t        new_entry;
  logic [7:0]    key;
  match_t        m;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] dcnt_next;
  logic [CW-1:0] wptr_next;

  fmpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RULES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fmpc_match u_match (
    .entry  (rd_data),
    .cmd    (cmd),
    .key    (key),
    .result (m)
  );

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_FIN);
  assign result    = res;
  assign cfg_ready = 1'b1;

  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign dcnt_next = m.name_eq ? dcnt + CW'(1) : dcnt;
  assign wptr_next = m.name_eq ? wptr : wptr + CW'(1);
  assign key       = (cmd.action == ACT_INSERT) ? cmd.after_name : cmd.rule_name;

  always_comb begin
    new_entry.name      = cmd.rule_name;
    new_entry.src_addr  = cmd.src_addr;
    new_entry.src_mask  = cmd.src_mask;
    new_entry.dst_addr  = cmd.dst_addr;
    new_entry.dst_mask  = cmd.dst_mask;
    new_entry.src_ports = cmd.src_ports;
    new_entry.dst_ports = cmd.dst_ports;
    new_entry.protocol  = cmd.protocol;
    new_entry.permit    = cmd.permit;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = rd_data;
    rd_addr = idx[IW-1:0];
    case (state)
      S_SCAN_EV: begin
        // compact kept rules toward the head
        wr_en   = (cmd.action == ACT_DELETE) && !m.name_eq;
        wr_addr = wptr[IW-1:0];
      end
      S_SHIFT_RD: begin
        rd_addr = idx_dec[IW-1:0];
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos[IW-1:0];
        wr_data = new_entry;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_accept <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      default_accept <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd  <= item;
            res  <= '0;
            idx  <= '0;
            wptr <= '0;
            dcnt <= '0;
            pos  <= '0;
            state <= S_FIN;
            case (item.action)
              ACT_CLASSIFY: begin
                res.add_session <= default_accept;
                if (count != '0) begin
                  state <= S_SCAN_RD;
                end
              end
              ACT_INSERT: begin
                if (count >= CW'(MAX_RULES)) begin
                  res.status <= ST_FULL;
                end else if (count != '0 && item.after_name != 8'd0) begin
                  state <= S_SCAN_RD;
                end else begin
                  idx   <= count;
                  state <= (count != '0) ? S_SHIFT_RD : S_PUT;
                end
              end
              ACT_DELETE: begin
                if (count != '0) begin
                  state <= S_SCAN_RD;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          idx   <= idx_inc;
          state <= (idx_inc == count) ? S_FIN : S_SCAN_RD;
          case (cmd.action)
            ACT_CLASSIFY: begin
              if (m.hit) begin
                res.verdict       <= rd_data.permit ? VD_ACCEPT : VD_DROP;
                res.add_session   <= rd_data.permit;
                res.matched_index <= 6'(idx);
                state             <= S_FIN;
              end
            end
            ACT_INSERT: begin
              if (m.name_eq) begin
                pos   <= idx_inc;
                idx   <= count;
                state <= (count > idx_inc) ? S_SHIFT_RD : S_PUT;
              end else if (idx_inc == count) begin
                res.status <= ST_NO_PRED;
              end
            end
            default: begin
              dcnt <= dcnt_next;
              wptr <= wptr_next;
              if (idx_inc == count) begin
                count             <= wptr_next;
                res.deleted_count <= 7'(dcnt_next);
              end
            end
          endcase
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          // moved entry idx-1 to idx; advance toward the insert point
          idx   <= idx_dec;
          state <= (idx_dec == pos) ? S_PUT : S_SHIFT_RD;
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fmpc_checker.sv
// ----------------------------------------------------------------------------
// fmpc_checker
// Port-level checks of the classifier's command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_match_packet_rule_classifier_assert.svh"

module fmpc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire fmpc_pkg::res_t result
);
  import fmpc_pkg::*;

  `FMPC_ASSERT(a_take_busy, start && !busy |=> busy, "busy not raised after a transaction")
  `FMPC_ASSERT(a_done_busy, done |-> busy, "result shown while idle")
  `FMPC_ASSERT(a_done_pulse, done |=> !done && !busy, "result not a single-cycle pulse")
  `FMPC_ASSERT(a_refused, done && result.status != ST_OK |-> result.verdict == VD_NONE && !result.add_session, "refused insert reports a verdict")
  `FMPC_ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> !busy && !done, "not idle after reset")

endmodule

bind first_match_packet_rule_classifier fmpc_checker u_fmpc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
